FILE: rtl/dbc_pkg.sv
// Shared types and constants for the DMA buffer cache.
// Used by dbc_ctrl, dbc_datapath and the top level.
`default_nettype none
package dbc_pkg;
   localparam int ENTRIES    = 32;
   localparam int RING_DEPTH = 64;
   localparam int IDX_W      = $clog2(ENTRIES);
   localparam int CNT_W      = IDX_W + 1;
   localparam int RING_AW    = $clog2(RING_DEPTH);

   localparam logic [CNT_W-1:0] ENTRY_MAX     = CNT_W'(ENTRIES);
   localparam logic [5:0]       TTL_LONG_HIT  = 6'd32;
   localparam logic [5:0]       TTL_SHORT_HIT = 6'd2;
   localparam logic [5:0]       TTL_FRESH     = 6'd3;

   typedef enum logic [1:0] {
      REG_SHORT_COUNT = 2'd0,
      REG_TOTAL_COUNT = 2'd1,
      REG_SHORT_BYTES = 2'd2,
      REG_LONG_BYTES  = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      RSP_HIT     = 2'd0,
      RSP_MISS    = 2'd1,
      RSP_NO_FREE = 2'd2,
      RSP_TICK    = 2'd3
   } rsp_status_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_CLEAR_START,
      OP_CLEAR_STEP,
      OP_TICK_STEP,
      OP_TICK_DONE,
      OP_INC,
      OP_SEL_NS,
      OP_SEL_HINT,
      OP_SEL_ZERO,
      OP_PULL,
      OP_HIT,
      OP_TAKE,
      OP_FAIL
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      long_pool;
   } dp_cmd_type;

   typedef struct packed {
      logic rebuild;
      logic clear_last;
      logic rsp_busy;
      logic func;
      logic long_lived;
      logic hint_ge_ns;
      logic cur_lt_nt;
      logic cur_lt_ns;
      logic covers;
      logic ttl_zero;
      logic short_nonempty;
      logic long_nonempty;
   } dp_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_DISPATCH,
      ST_TICK,
      ST_LSCAN,
      ST_SPROBE,
      ST_SSCAN,
      ST_PULL_RD,
      ST_PULL_WR,
      ST_HIT,
      ST_TAKE_RD,
      ST_TAKE_WR
   } ctrl_state_type;
endpackage
`default_nettype wire

FILE: rtl/dbc_datapath.sv
// Entry tables, reuse rings, counters and the result register of the buffer cache.
// Driven by dbc_ctrl through dp_cmd_type; depends on dbc_pkg.
`default_nettype none
module dbc_datapath
   import dbc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_func,
   input  wire logic [31:0] req_dev_addr,
   input  wire logic [15:0] req_req_bytes,
   input  wire logic        req_long_lived,
   input  wire logic [4:0]  req_index_hint,
   input  wire logic [2:0]  req_medium_req,
   input  wire logic        rsp_ready,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [4:0]       rsp_entry_index,
   output logic [15:0]      rsp_byte_offset,
   output logic [4:0]       rsp_new_hint,
   output logic             rsp_dma_start,
   output logic [31:0]      rsp_dma_addr,
   output logic [15:0]      rsp_dma_bytes,
   output logic [2:0]       rsp_dma_medium,
   input  wire dp_cmd_type  cmd,
   output dp_status_type    sts
);
   logic [5:0]  short_cnt_ff, total_cnt_ff;
   logic [15:0] short_bytes_ff, long_bytes_ff;
   logic        rebuild_ff;

   logic [31:0] ent_addr_ff [ENTRIES];
   logic [5:0]  ent_ttl_ff  [ENTRIES];
   logic [RING_AW-1:0] ent_pos_ff [ENTRIES];

   logic [IDX_W-1:0] sring [RING_DEPTH];
   logic [IDX_W-1:0] lring [RING_DEPTH];
   logic [IDX_W-1:0] srdata_ff, lrdata_ff;
   logic [RING_AW-1:0] srd_ff, swr_ff, lrd_ff, lwr_ff;

   logic [RING_AW-1:0] cur_ff;
   logic        func_ff, long_ff;
   logic [31:0] addr_ff;
   logic [15:0] bytes_ff;
   logic [4:0]  hint_ff;
   logic [2:0]  medium_ff;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [4:0]  rsp_index_ff, rsp_hint_ff;
   logic [15:0] rsp_offset_ff, rsp_dbytes_ff;
   logic        rsp_start_ff;
   logic [31:0] rsp_daddr_ff;
   logic [2:0]  rsp_medium_ff;

   logic [CNT_W-1:0] ns, nt, nl;
   logic [IDX_W-1:0] e, head, take_idx;
   logic [15:0] size, take_size;
   logic [31:0] diff, aligned;
   logic [5:0]  ttl_e;
   logic        push, push_long, move;
   logic [RING_AW-1:0] p, r;
   logic        s_we, l_we;
   logic [RING_AW-1:0] s_wa, l_wa;
   logic [IDX_W-1:0] s_wd, l_wd;

   always_comb begin
      ns = (short_cnt_ff > 6'(ENTRY_MAX)) ? ENTRY_MAX : CNT_W'(short_cnt_ff);
      nt = (total_cnt_ff > 6'(ENTRY_MAX)) ? ENTRY_MAX : CNT_W'(total_cnt_ff);
      nl = (nt > ns) ? CNT_W'(nt - ns) : '0;
      e = cur_ff[IDX_W-1:0];
      size = ({1'b0, e} < ns) ? short_bytes_ff : long_bytes_ff;
      diff = addr_ff - ent_addr_ff[e];
      aligned = {addr_ff[31:4], 4'b0000};
      ttl_e = ent_ttl_ff[e];
      push = (cmd.op == OP_TICK_STEP) && (ttl_e == 6'd1);
      push_long = !({1'b0, e} < ns);
      p = ent_pos_ff[e];
      r = cmd.long_pool ? lrd_ff : srd_ff;
      head = cmd.long_pool ? lrdata_ff : srdata_ff;
      move = (cmd.op == OP_PULL) && (p != r);
      take_idx = cmd.long_pool ? lrdata_ff : srdata_ff;
      take_size = ({1'b0, take_idx} < ns) ? short_bytes_ff : long_bytes_ff;

      s_we = 1'b0;
      s_wa = cur_ff;
      s_wd = '0;
      l_we = 1'b0;
      l_wa = cur_ff;
      l_wd = '0;
      if (cmd.op == OP_CLEAR_STEP) begin
         s_we = 1'b1;
         s_wd = ({1'b0, cur_ff} < {1'b0, RING_AW'(ns)}) ? cur_ff[IDX_W-1:0] : '0;
         l_we = 1'b1;
         l_wd = ({1'b0, cur_ff} < {1'b0, RING_AW'(nl)}) ?
                IDX_W'(RING_AW'(ns) + cur_ff) : '0;
      end else if (push) begin
         if (push_long) begin
            l_we = 1'b1;
            l_wa = lwr_ff;
            l_wd = e;
         end else begin
            s_we = 1'b1;
            s_wa = swr_ff;
            s_wd = e;
         end
      end else if (move) begin
         if (cmd.long_pool) begin
            l_we = 1'b1;
            l_wa = p;
            l_wd = head;
         end else begin
            s_we = 1'b1;
            s_wa = p;
            s_wd = head;
         end
      end
   end

   always_comb begin
      sts.rebuild        = rebuild_ff;
      sts.clear_last     = (cur_ff == RING_AW'(RING_DEPTH - 1));
      sts.rsp_busy       = rsp_valid_ff;
      sts.func           = func_ff;
      sts.long_lived     = long_ff;
      sts.hint_ge_ns     = ({1'b0, hint_ff} >= ns);
      sts.cur_lt_nt      = ({1'b0, cur_ff} < {1'b0, RING_AW'(nt)});
      sts.cur_lt_ns      = ({1'b0, cur_ff} < {1'b0, RING_AW'(ns)});
      sts.covers         = !diff[31] && (bytes_ff <= size) &&
                           (diff <= {16'b0, size - bytes_ff});
      sts.ttl_zero       = (ttl_e == 6'd0);
      sts.short_nonempty = (srd_ff != swr_ff);
      sts.long_nonempty  = (lrd_ff != lwr_ff);
   end

   always_ff @(posedge clock) begin
      if (s_we) sring[s_wa] <= s_wd;
      if (l_we) lring[l_wa] <= l_wd;
      srdata_ff <= sring[srd_ff];
      lrdata_ff <= lring[lrd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_cnt_ff   <= 6'd16;
         total_cnt_ff   <= 6'd32;
         short_bytes_ff <= 16'd1024;
         long_bytes_ff  <= 16'd1024;
         rebuild_ff     <= 1'b1;
      end else begin
         if (cmd.op == OP_CLEAR_START) rebuild_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               REG_SHORT_COUNT: begin
                  short_cnt_ff <= csr_wdata[5:0];
                  rebuild_ff   <= 1'b1;
               end
               REG_TOTAL_COUNT: begin
                  total_cnt_ff <= csr_wdata[5:0];
                  rebuild_ff   <= 1'b1;
               end
               REG_SHORT_BYTES: short_bytes_ff <= csr_wdata;
               REG_LONG_BYTES:  long_bytes_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_CLEAR_START: begin
            for (int i = 0; i < ENTRIES; i++) begin
               ent_addr_ff[i] <= '0;
               ent_ttl_ff[i]  <= '0;
               if (CNT_W'(i) < ns)
                  ent_pos_ff[i] <= RING_AW'(i);
               else if (CNT_W'(i) < nt)
                  ent_pos_ff[i] <= RING_AW'(CNT_W'(i) - ns);
               else
                  ent_pos_ff[i] <= '0;
            end
         end
         OP_TICK_STEP: begin
            if (ttl_e != 6'd0) ent_ttl_ff[e] <= ttl_e - 6'd1;
            if (push) ent_pos_ff[e] <= push_long ? lwr_ff : swr_ff;
         end
         OP_PULL: begin
            if (move) ent_pos_ff[head] <= p;
         end
         OP_HIT: begin
            ent_ttl_ff[e] <= cmd.long_pool ? TTL_LONG_HIT : TTL_SHORT_HIT;
         end
         OP_TAKE: begin
            ent_ttl_ff[take_idx]  <= TTL_FRESH;
            ent_addr_ff[take_idx] <= aligned;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         srd_ff <= '0;
         swr_ff <= '0;
         lrd_ff <= '0;
         lwr_ff <= '0;
         cur_ff <= '0;
      end else begin
         case (cmd.op)
            OP_CLEAR_START: begin
               srd_ff <= '0;
               lrd_ff <= '0;
               swr_ff <= RING_AW'(ns);
               lwr_ff <= RING_AW'(nl);
               cur_ff <= '0;
            end
            OP_CLEAR_STEP, OP_INC: cur_ff <= cur_ff + 1'b1;
            OP_TICK_STEP: begin
               cur_ff <= cur_ff + 1'b1;
               if (push) begin
                  if (push_long) lwr_ff <= lwr_ff + 1'b1;
                  else swr_ff <= swr_ff + 1'b1;
               end
            end
            OP_ACCEPT, OP_SEL_ZERO: cur_ff <= '0;
            OP_SEL_NS:   cur_ff <= RING_AW'(ns);
            OP_SEL_HINT: cur_ff <= RING_AW'(hint_ff);
            OP_PULL, OP_TAKE: begin
               if (cmd.long_pool) lrd_ff <= lrd_ff + 1'b1;
               else srd_ff <= srd_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_ACCEPT) begin
         func_ff   <= req_func;
         addr_ff   <= req_dev_addr;
         bytes_ff  <= req_req_bytes;
         long_ff   <= req_long_lived;
         hint_ff   <= req_index_hint;
         medium_ff <= req_medium_req;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_HIT || cmd.op == OP_TAKE ||
                   cmd.op == OP_FAIL || cmd.op == OP_TICK_DONE) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_HIT: begin
            rsp_status_ff <= RSP_HIT;
            rsp_index_ff  <= e;
            rsp_offset_ff <= diff[15:0];
            rsp_hint_ff   <= cmd.long_pool ? e : hint_ff;
            rsp_start_ff  <= 1'b0;
            rsp_daddr_ff  <= '0;
            rsp_dbytes_ff <= '0;
            rsp_medium_ff <= '0;
         end
         OP_TAKE: begin
            rsp_status_ff <= RSP_MISS;
            rsp_index_ff  <= take_idx;
            rsp_offset_ff <= {12'b0, addr_ff[3:0]};
            rsp_hint_ff   <= take_idx;
            rsp_start_ff  <= 1'b1;
            rsp_daddr_ff  <= aligned;
            rsp_dbytes_ff <= take_size;
            rsp_medium_ff <= medium_ff;
         end
         OP_FAIL, OP_TICK_DONE: begin
            rsp_status_ff <= (cmd.op == OP_FAIL) ? RSP_NO_FREE : RSP_TICK;
            rsp_index_ff  <= '0;
            rsp_offset_ff <= '0;
            rsp_hint_ff   <= (cmd.op == OP_FAIL) ? hint_ff : 5'd0;
            rsp_start_ff  <= 1'b0;
            rsp_daddr_ff  <= '0;
            rsp_dbytes_ff <= '0;
            rsp_medium_ff <= '0;
         end
         default: ;
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_index = rsp_index_ff;
   assign rsp_byte_offset = rsp_offset_ff;
   assign rsp_new_hint    = rsp_hint_ff;
   assign rsp_dma_start   = rsp_start_ff;
   assign rsp_dma_addr    = rsp_daddr_ff;
   assign rsp_dma_bytes   = rsp_dbytes_ff;
   assign rsp_dma_medium  = rsp_medium_ff;
endmodule
`default_nettype wire

FILE: rtl/dbc_ctrl.sv
// Sequencer for the buffer cache: clear sweep, tick aging, search, pull and take.
// Drives dbc_datapath through dp_cmd_type; depends on dbc_pkg.
`default_nettype none
module dbc_ctrl
   import dbc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire dp_status_type sts,
   output dp_cmd_type   cmd
);
   ctrl_state_type state_ff, state_in;
   logic pool_ff, pool_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pool_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pool_ff  <= pool_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      pool_in  = pool_ff;
      case (state_ff)
         ST_IDLE: begin
            if (sts.rebuild) state_in = ST_CLEAR;
            else if (req_valid && !sts.rsp_busy) state_in = ST_DISPATCH;
         end
         ST_CLEAR: begin
            if (sts.rebuild) state_in = ST_IDLE;
            else if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_DISPATCH: begin
            if (!sts.func) state_in = ST_TICK;
            else if (sts.long_lived || sts.hint_ge_ns) state_in = ST_LSCAN;
            else state_in = ST_SPROBE;
         end
         ST_TICK: begin
            if (!sts.cur_lt_nt) state_in = ST_IDLE;
         end
         ST_LSCAN: begin
            if (sts.cur_lt_nt) begin
               if (sts.covers) begin
                  pool_in  = 1'b1;
                  state_in = (sts.ttl_zero && sts.long_nonempty) ? ST_PULL_RD : ST_HIT;
               end
            end else if (sts.long_lived && sts.long_nonempty) begin
               pool_in  = 1'b1;
               state_in = ST_TAKE_RD;
            end else if (!sts.long_lived) begin
               state_in = ST_SPROBE;
            end else if (sts.short_nonempty) begin
               pool_in  = 1'b0;
               state_in = ST_TAKE_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SPROBE: begin
            if (!sts.hint_ge_ns && sts.covers) begin
               pool_in  = 1'b0;
               state_in = (sts.ttl_zero && sts.short_nonempty) ? ST_PULL_RD : ST_HIT;
            end else begin
               state_in = ST_SSCAN;
            end
         end
         ST_SSCAN: begin
            if (sts.cur_lt_ns) begin
               if (sts.covers) begin
                  pool_in  = 1'b0;
                  state_in = (sts.ttl_zero && sts.short_nonempty) ? ST_PULL_RD : ST_HIT;
               end
            end else if (sts.short_nonempty) begin
               pool_in  = 1'b0;
               state_in = ST_TAKE_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PULL_RD: state_in = ST_PULL_WR;
         ST_PULL_WR: state_in = ST_HIT;
         ST_HIT:     state_in = ST_IDLE;
         ST_TAKE_RD: state_in = ST_TAKE_WR;
         ST_TAKE_WR: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op        = OP_NONE;
      cmd.long_pool = pool_ff;
      req_ready     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (sts.rebuild) begin
               cmd.op = OP_CLEAR_START;
            end else begin
               req_ready = !sts.rsp_busy;
               if (req_valid && !sts.rsp_busy) cmd.op = OP_ACCEPT;
            end
         end
         ST_CLEAR: cmd.op = sts.rebuild ? OP_NONE : OP_CLEAR_STEP;
         ST_DISPATCH: begin
            if (sts.func) begin
               cmd.op = (sts.long_lived || sts.hint_ge_ns) ? OP_SEL_NS : OP_SEL_HINT;
            end
         end
         ST_TICK: cmd.op = sts.cur_lt_nt ? OP_TICK_STEP : OP_TICK_DONE;
         ST_LSCAN: begin
            if (sts.cur_lt_nt) begin
               if (!sts.covers) cmd.op = OP_INC;
            end else if (!sts.long_lived) begin
               cmd.op = OP_SEL_HINT;
            end else if (!sts.long_nonempty && !sts.short_nonempty) begin
               cmd.op = OP_FAIL;
            end
         end
         ST_SPROBE: begin
            if (sts.hint_ge_ns || !sts.covers) cmd.op = OP_SEL_ZERO;
         end
         ST_SSCAN: begin
            if (sts.cur_lt_ns) begin
               if (!sts.covers) cmd.op = OP_INC;
            end else if (!sts.short_nonempty) begin
               cmd.op = OP_FAIL;
            end
         end
         ST_PULL_WR: cmd.op = OP_PULL;
         ST_HIT:     cmd.op = OP_HIT;
         ST_TAKE_WR: cmd.op = OP_TAKE;
         default:    cmd.op = OP_NONE;
      endcase
   end
endmodule
`default_nettype wire

FILE: rtl/dma_buffer_cache_ttl_reuse_top.sv
// Top level of the DMA staging buffer cache with time-to-live and reuse rings.
// Instantiates dbc_ctrl and dbc_datapath; depends on dbc_pkg.
//
// One beat in, one beat out, one item at a time; the next beat is taken only
// after the result beat has left. A tick ages each of the total-count entries
// in turn and then returns its result. A request is accepted and dispatched,
// then scans entry by entry (the long pool first for long-lived requests and
// for a hint in the long pool; short-lived ones then probe the hint and scan
// the short pool), and ends in a plain hit, a hit that pulls the entry from
// its ring, a ring take or a no-free result; each scan step reads one entry.
// After reset and after each write of either count register the block
// rebuilds both 64-deep reuse rings before it takes a beat.
`default_nettype none
module dma_buffer_cache_ttl_reuse_top
   import dbc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_func,
   input  wire logic [31:0] req_dev_addr,
   input  wire logic [15:0] req_req_bytes,
   input  wire logic        req_long_lived,
   input  wire logic [4:0]  req_index_hint,
   input  wire logic [2:0]  req_medium_req,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [4:0]       rsp_entry_index,
   output logic [15:0]      rsp_byte_offset,
   output logic [4:0]       rsp_new_hint,
   output logic             rsp_dma_start,
   output logic [31:0]      rsp_dma_addr,
   output logic [15:0]      rsp_dma_bytes,
   output logic [2:0]       rsp_dma_medium
);
   dp_cmd_type    cmd;
   dp_status_type sts;

   dbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dbc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_func        (req_func),
      .req_dev_addr    (req_dev_addr),
      .req_req_bytes   (req_req_bytes),
      .req_long_lived  (req_long_lived),
      .req_index_hint  (req_index_hint),
      .req_medium_req  (req_medium_req),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_entry_index (rsp_entry_index),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_new_hint    (rsp_new_hint),
      .rsp_dma_start   (rsp_dma_start),
      .rsp_dma_addr    (rsp_dma_addr),
      .rsp_dma_bytes   (rsp_dma_bytes),
      .rsp_dma_medium  (rsp_dma_medium),
      .cmd             (cmd),
      .sts             (sts)
   );
endmodule
`default_nettype wire
